// ===== hw/rtl/temperature_seven_segment_scan_core_defines.svh =====
// assertion macros used by the temperature display top-level rtl
`ifndef TEMPERATURE_SEVEN_SEGMENT_SCAN_CORE_DEFINES_SVH
`define TEMPERATURE_SEVEN_SEGMENT_SCAN_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, idle while reset is held
`define TSSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define TSSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/tsss_pkg.sv =====
// types, constants and segment table for the temperature display core
`timescale 1ns / 1ps

package tsss_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 11;
    localparam int DIGIT_W  = 4;
    localparam int NUM_POS  = 4;
    localparam int POS_W    = 2;
    localparam int SEG_W    = 7;
    localparam int STAGES   = 5;

    // (s*5940 - 2375680) / 40960 reduced by 4 -> (s*1485 - 593920) / 10240
    localparam int PROD_W      = 23;
    localparam int CONV_MUL    = 1485;
    localparam int CONV_OFFSET = 593920;
    localparam int QUOT_W      = 13;   // magnitude >> 10
    localparam int RECIP_10    = 52429; // floor(q/10) = (q*52429) >> 19
    localparam int RECIP_10_SH = 19;
    localparam int RECIP_W     = 29;
    localparam int MAG_W       = 10;
    localparam int RECIP_100   = 5243;  // floor(t/100) = (t*5243) >> 19
    localparam int RECIP_100_W = 23;
    localparam int TENS_MUL    = 205;   // floor(r/10) = (r*205) >> 11 for r < 100
    localparam int TENS_SH     = 11;
    localparam int TENS_W      = 15;

    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

    typedef logic [NUM_POS-1:0][DIGIT_W-1:0] t_digits; // [0] thousands .. [3] units

    typedef struct packed {
        logic                     action;
        logic signed [TEMP_W-1:0] temp;
        t_digits                  digits;
    } t_conv_item;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/tsss_conv.sv =====
// pipelined sample to fahrenheit conversion with decimal digit split
`timescale 1ns / 1ps

module tsss_conv
    import tsss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_hs                 o_hs_out,   // valid from last stage
    input  logic                i_out_ready,
    output t_conv_item          o_item
);

    logic [STAGES-1:0] r_v;
    logic [STAGES-2:0] r_act;
    logic [STAGES:0]   w_rdy;

    logic [SAMPLE_W-1:0]    r_smp1;
    logic [PROD_W-1:0]      r_prod2;
    logic [RECIP_W-1:0]     r_p3;
    logic                   r_neg3;
    logic [MAG_W-1:0]       r_t4;
    logic                   r_neg4;
    logic [DIGIT_W-1:0]     r_hc4;
    t_conv_item             r_item5;

    logic signed [PROD_W:0] w_diff;
    logic [PROD_W-1:0]      w_mag;
    logic [QUOT_W-1:0]      w_q;
    logic [RECIP_W-1:0]     w_p;
    logic [MAG_W-1:0]       w_t3;
    logic [RECIP_100_W-1:0] w_h_prod;
    logic                   w_th;
    logic [DIGIT_W-1:0]     w_hund;
    logic [MAG_W-1:0]       w_rem;
    logic [TENS_W-1:0]      w_tens_prod;
    logic [DIGIT_W-1:0]     w_tens;
    logic [DIGIT_W-1:0]     w_units;
    logic signed [TEMP_W-1:0] w_temp;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_rdy[STAGES] = i_out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 3 arithmetic: signed offset, magnitude, divide by 10240
    assign w_diff = $signed({1'b0, r_prod2}) - (PROD_W + 1)'(CONV_OFFSET);
    assign w_mag  = w_diff[PROD_W] ? PROD_W'(-w_diff) : w_diff[PROD_W-1:0];
    assign w_q    = w_mag[PROD_W-1 -: QUOT_W];
    assign w_p    = RECIP_W'(w_q) * RECIP_W'(RECIP_10);

    // stage 4: hundreds count of the magnitude (0..10)
    assign w_t3     = r_p3[RECIP_10_SH +: MAG_W];
    assign w_h_prod = RECIP_100_W'(w_t3) * RECIP_100_W'(RECIP_100);

    // stage 5: split into digits
    assign w_th        = (r_hc4 >= DIGIT_W'(10));
    assign w_hund      = w_th ? r_hc4 - DIGIT_W'(10) : r_hc4;
    assign w_rem       = r_t4 - MAG_W'(r_hc4) * MAG_W'(100);
    assign w_tens_prod = TENS_W'(w_rem) * TENS_W'(TENS_MUL);
    assign w_tens      = w_tens_prod[TENS_SH +: DIGIT_W];
    assign w_units     = DIGIT_W'(w_rem - MAG_W'(w_tens) * MAG_W'(10));
    assign w_temp      = r_neg4 ? -$signed({1'b0, r_t4}) : $signed({1'b0, r_t4});

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_act[0] <= i_action;
            r_smp1   <= i_sample;
        end
        if (w_rdy[1]) begin
            r_act[1] <= r_act[0];
            r_prod2  <= PROD_W'(r_smp1) * PROD_W'(CONV_MUL);
        end
        if (w_rdy[2]) begin
            r_act[2] <= r_act[1];
            r_p3     <= w_p;
            r_neg3   <= w_diff[PROD_W];
        end
        if (w_rdy[3]) begin
            r_act[3] <= r_act[2];
            r_t4     <= w_t3;
            r_neg4   <= r_neg3;
            r_hc4    <= w_h_prod[RECIP_10_SH +: DIGIT_W];
        end
        if (w_rdy[4]) begin
            r_item5.action <= r_act[3];
            r_item5.temp   <= w_temp;
            // below zero the display shows 0000
            if (r_neg4) begin
                r_item5.digits <= '0;
            end else begin
                r_item5.digits <= {w_units, w_tens, w_hund, {(DIGIT_W-1){1'b0}}, w_th};
            end
        end
    end

    assign o_hs_out.valid = r_v[STAGES-1];
    assign o_hs_out.ready = w_rdy[STAGES];
    assign o_item         = r_item5;

endmodule

// ===== hw/rtl/temperature_seven_segment_scan_core.sv =====
// Temperature display core: a stream of sensor samples (tuser 0) and scan ticks (tuser 1)
// comes in, one transaction per cycle while s_axis_tready is high. Each sample is turned
// into whole degrees Fahrenheit, trunc((s*5940 - 2375680)/40960), and kept; each tick
// drives the next of four digit positions, thousands to units, latching fresh digits at
// the thousands position. Every input transaction gives exactly one output transaction
// with the digit select, the active-low segment pattern and the kept temperature.
// Temperatures below zero show as 0000. Data passes through a five-stage conversion
// pipeline and the output register; throughput is one transaction per cycle while the
// output is not stalled, and bubbles in the pipeline still take input while it is stalled.
`timescale 1ns / 1ps
`include "temperature_seven_segment_scan_core_defines.svh"

module temperature_seven_segment_scan_core
    import tsss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample, rest zero
    input  logic        s_axis_tuser,   // [0] action: 0 sample, 1 scan tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [3:0] digit_select, [10:4] segments,
                                        // [21:11] fahrenheit, rest zero
);

    t_hs        w_conv_hs;
    t_conv_item w_item;
    logic       w_conv_ready;
    logic       w_upd;

    logic                     r_out_v;
    logic [NUM_POS-1:0]       r_out_sel;
    logic [SEG_W-1:0]         r_out_seg;
    logic signed [TEMP_W-1:0] r_out_temp;

    logic signed [TEMP_W-1:0] r_temp;
    t_digits                  r_ldig;   // digits of the kept temperature
    t_digits                  r_shown;  // digits latched for the scan
    logic [POS_W-1:0]         r_pos;

    logic [POS_W-1:0] w_pos_show;
    t_digits          w_shown;
    logic [DIGIT_W-1:0] w_digit;

    tsss_conv u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_sample   (s_axis_tdata[SAMPLE_W-1:0]),
        .o_hs_out   (w_conv_hs),
        .i_out_ready(w_conv_ready),
        .o_item     (w_item)
    );

    assign w_conv_ready = !r_out_v || m_axis_tready;
    assign w_upd        = w_conv_hs.valid && w_conv_ready;

    // a sample repeats the position driven last
    assign w_pos_show = w_item.action ? r_pos : r_pos - POS_W'(1);
    assign w_shown    = (w_item.action && r_pos == '0) ? r_ldig : r_shown;
    assign w_digit    = w_shown[w_pos_show];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_temp  <= '0;
            r_ldig  <= '0;
            r_shown <= '0;
            r_pos   <= '0;
        end else begin
            if (w_upd) begin
                r_out_v <= 1'b1;
                if (w_item.action) begin
                    r_shown <= w_shown;
                    r_pos   <= r_pos + POS_W'(1);
                end else begin
                    r_temp <= w_item.temp;
                    r_ldig <= w_item.digits;
                end
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_out_sel  <= NUM_POS'(1) << w_pos_show;
            r_out_seg  <= seg_lookup(w_digit);
            r_out_temp <= w_item.action ? r_temp : w_item.temp;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {2'b00, r_out_temp, r_out_seg, r_out_sel};

    `TSSS_ASSERT(a_sel_onehot, i_clk, i_rst_n, r_out_v |-> $onehot(r_out_sel), "digit select not one-hot")
    `TSSS_ASSERT(a_tick_adv, i_clk, i_rst_n, (w_upd && w_item.action) |=> (r_pos == $past(r_pos) + POS_W'(1)), "scan did not advance on tick")
    `TSSS_ASSERT(a_sample_keep, i_clk, i_rst_n, (w_upd && !w_item.action) |=> (r_temp == $past(w_item.temp) && r_pos == $past(r_pos)), "sample not kept or scan moved")
    `TSSS_ASSERT_ALWAYS(a_neg_zero, i_clk, r_temp[TEMP_W-1] |-> (r_ldig == '0), "negative temperature with nonzero digits")

endmodule

// ===== bench/tb_temperature_seven_segment_scan_core.sv =====
// testbench for the temperature display scan core: stream stimulus, predictor and scoreboard
`timescale 1ns / 1ps

module tb_temperature_seven_segment_scan_core;
    import tsss_pkg::*;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam int N_RANDOM    = 1800;
    localparam int HOLD_AFTER  = 500;   // inputs accepted before the long receiver hold
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 900;   // random item index where the sender waits for a drain
    localparam int TAIL_CYCLES = 12;

    typedef struct {
        logic [NUM_POS-1:0]       sel;
        logic [SEG_W-1:0]         seg;
        logic signed [TEMP_W-1:0] temp;
    } t_frame;

    class seg_display_board;
        int                       errors;
        t_frame                   pending_frames[$];
        logic signed [TEMP_W-1:0] kept_temp;
        logic [DIGIT_W-1:0]       latched_digits[NUM_POS];
        logic [POS_W-1:0]         next_pos;
        logic [SEG_W-1:0]         seg_codes[10] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                                                   7'h12, 7'h02, 7'h78, 7'h00, 7'h10};

        function new();
            errors    = 0;
            kept_temp = '0;
            next_pos  = '0;
            foreach (latched_digits[k]) latched_digits[k] = '0;
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction

        // exact integer form of the volts -> celsius -> fahrenheit chain, truncated toward zero
        function int degrees_f(logic [SAMPLE_W-1:0] s);
            int num;
            num = int'(s) * 5940 - 2375680;
            return num / 40960;
        endfunction

        function void latch_from_temp();
            int v;
            v = kept_temp;
            for (int k = NUM_POS - 1; k >= 0; k--) begin
                latched_digits[k] = (v < 0) ? '0 : DIGIT_W'(v % 10);
                if (v >= 0) v = v / 10;
            end
        endfunction

        function void note_accepted(logic act, logic [SAMPLE_W-1:0] smp);
            t_frame             f;
            logic [POS_W-1:0]   pos;
            logic [DIGIT_W-1:0] d;
            if (act == ACT_SAMPLE) begin
                kept_temp = TEMP_W'(degrees_f(smp));
                // a sample repeats whatever position was driven last
                pos = next_pos - POS_W'(1);
            end else begin
                pos = next_pos;
                if (pos == '0) latch_from_temp();
                next_pos = next_pos + POS_W'(1);
            end
            d      = latched_digits[pos];
            f.sel  = NUM_POS'(1) << pos;
            f.seg  = (d < 10) ? seg_codes[d] : 7'h7F;
            f.temp = kept_temp;
            pending_frames.push_back(f);
        endfunction

        function void check_frame(logic [23:0] data);
            t_frame f;
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: output transaction with nothing expected, actual %h",
                         $time, data);
                return;
            end
            f = pending_frames.pop_front();
            if (data[3:0] !== f.sel) begin
                errors++;
                $display("%0t: digit_select expected %h actual %h", $time, f.sel, data[3:0]);
            end
            if (data[10:4] !== f.seg) begin
                errors++;
                $display("%0t: segments expected %h actual %h", $time, f.seg, data[10:4]);
            end
            if (data[21:11] !== f.temp) begin
                errors++;
                $display("%0t: fahrenheit expected %0d actual %0d", $time, f.temp,
                         $signed(data[21:11]));
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [11:0] sample, rest zero
    logic        s_axis_tuser  = 1'b0; // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [3:0] digit_select, [10:4] segments, [21:11] fahrenheit

    seg_display_board board = new();
    int               n_sent = 0;
    int               burst_left = 0;

    temperature_seven_segment_scan_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_frame(m_axis_tdata);
    end

    // one transaction; when the current burst runs out, a new burst length and usually a random gap
    task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_accepted(act, smp);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 16'($urandom);
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] corner[6] = '{12'd0, 12'd4095, 12'd393, 12'd394, 12'd400, 12'd3600};
        if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 5)];
        return SAMPLE_W'($urandom);
    endfunction

    // receiver: rotating stall patterns plus one long hold while the sender keeps going
    initial begin
        int  cyc;
        bit  held;
        cyc  = 0;
        held = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!held && n_sent >= HOLD_AFTER) begin
                held = 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case ((cyc / 200) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= ((cyc % 4) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        logic [SAMPLE_W-1:0] directed[5];
        logic                act;
        directed = '{12'd0, 12'd393, 12'd394, 12'd4095, 12'd3600};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // each sample then a full scan: the first one checks the units repeat after reset
        foreach (directed[k]) begin
            send_item(ACT_SAMPLE, directed[k]);
            repeat (NUM_POS) send_item(ACT_TICK, SAMPLE_W'($urandom));
        end
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == DRAIN_AT) wait_drained();
            act = ($urandom_range(0, 99) < 35) ? ACT_SAMPLE : ACT_TICK;
            send_item(act, (act == ACT_SAMPLE) ? pick_sample() : SAMPLE_W'($urandom));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
